### rtl/bst_pkg.sv
// Types, codes and keyword tables shared by the byte stream tokenizer.
package bst_pkg;

    localparam int KW_COUNT = 3;

    // Keyword order: int, return, if.
    localparam logic [1:0] KW_INT    = 2'd0;
    localparam logic [1:0] KW_RETURN = 2'd1;
    localparam logic [1:0] KW_IF     = 2'd2;

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd6, 3'd2};

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_NUMBER = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KIND_KEYWORD      = 3'd0,
        KIND_IDENT        = 3'd1,
        KIND_NUMBER       = 3'd2,
        KIND_OPERATOR     = 3'd3,
        KIND_UNRECOGNIZED = 3'd4
    } kind_t;

    typedef struct packed {
        logic       last;
        logic       sat;
        logic [7:0] first;
        logic [6:0] len;
        logic [1:0] kwi;
        kind_t      kind;
    } result_t;

    // Character of keyword k at position pos; zero past the end of the keyword.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            KW_INT: begin
                case (pos)
                    3'd0:    ch = "i";
                    3'd1:    ch = "n";
                    3'd2:    ch = "t";
                    default: ch = 8'h00;
                endcase
            end
            KW_RETURN: begin
                case (pos)
                    3'd0:    ch = "r";
                    3'd1:    ch = "e";
                    3'd2:    ch = "t";
                    3'd3:    ch = "u";
                    3'd4:    ch = "r";
                    3'd5:    ch = "n";
                    default: ch = 8'h00;
                endcase
            end
            KW_IF: begin
                case (pos)
                    3'd0:    ch = "i";
                    3'd1:    ch = "f";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {8'd32, [8'd9:8'd13]});
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c inside {"+", "-", "*", "/", "=", "<", ">"});
    endfunction

endpackage

### rtl/byte_stream_tokenizer.sv
// Byte stream tokenizer top level: scanner state, token decision and result queue.
//
//  Channel | Dir | tdata                      | tlast        | Meaning
//  s_      | in  | [7:0] text_byte            | end_of_text  | one text byte per transfer
//  m_      | out | [2:0] token_kind,          | last_of_run  | one token per transfer
//          |     | [4:3] keyword_index,       |              |
//          |     | [11:5] token_length,       |              |
//          |     | [19:12] first_byte,        |              |
//          |     | [20] length_saturated      |              |
//
// A byte is decided in the cycle it is accepted; its tokens are registered into the result queue, whose head drives m_.
// One byte per cycle is sustained while the queue holds at most one token; a byte that yields two
// tokens can stall the input, since the single output port drains a three-entry result queue.
// s_tready is high while the queue holds at most one token, so it does not depend
// on m_tready. Reset (aresetn low, synchronous) empties the queue and idles the scanner.
module byte_stream_tokenizer
    import bst_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = 127
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // kind, keyword_index, length, first_byte, saturated
    output logic        m_tlast    // last_of_run
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int QDEPTH = 3;

    typedef struct packed {
        mode_t            mode;
        logic [LEN_W-1:0] len;
        logic [2:0]       kw;
        logic [7:0]       first;
        logic             sat;
    } scan_t;

    localparam scan_t SCAN_IDLE = '{mode: MODE_IDLE, len: '0, kw: 3'b000,
                                    first: 8'h00, sat: 1'b0};

    function automatic logic [2:0] match_kw(input logic [2:0] kw, input logic [LEN_W-1:0] pos,
                                            input logic [7:0] c);
        logic [2:0] m;
        m = kw;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (pos >= LEN_W'(KW_LEN[k]) || kw_char(2'(k), pos[2:0]) != c) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic scan_t append(input scan_t s, input logic [7:0] c);
        scan_t r;
        r = s;
        if (s.len >= LEN_W'(MAX_TOKEN_LENGTH)) begin
            r.sat = 1'b1;
            r.kw  = 3'b000;
        end else begin
            if (s.mode == MODE_WORD) begin
                r.kw = match_kw(s.kw, s.len, c);
            end
            r.len = s.len + 1'b1;
        end
        return r;
    endfunction

    function automatic result_t flush_res(input scan_t s);
        result_t r;
        r.kind  = (s.mode == MODE_WORD) ? KIND_IDENT : KIND_NUMBER;
        r.kwi   = 2'd0;
        r.len   = 7'(s.len);
        r.first = s.first;
        r.sat   = s.sat;
        r.last  = 1'b0;
        if (s.mode == MODE_WORD) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (s.kw[k] && !s.sat && s.len == LEN_W'(KW_LEN[k])) begin
                    r.kind = KIND_KEYWORD;
                    r.kwi  = 2'(k);
                end
            end
        end
        return r;
    endfunction

    scan_t            scan_reg, scan_next;
    result_t          q_reg [QDEPTH];
    result_t          q_next [QDEPTH];
    result_t          q_sh [QDEPTH];
    logic [1:0]       count_reg, count_next;

    logic             push, pop;
    logic [7:0]       c;
    logic             letter, digit, space, op, extend;
    scan_t            mid, started;
    result_t          res_a, res_b, r0, r1;
    logic             a_valid, b_valid;
    logic [1:0]       n_res;
    logic [1:0]       base;

    assign s_tready = (count_reg <= 2'd1);
    assign push     = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {3'b000, q_reg[0].sat, q_reg[0].first, q_reg[0].len, q_reg[0].kwi,
                       q_reg[0].kind};
    assign m_tlast  = q_reg[0].last;

    // Token decision for the byte at the input.
    always_comb begin
        c      = s_tdata;
        letter = is_letter(c);
        digit  = is_digit(c);
        space  = is_space(c);
        op     = is_op(c);
        extend = (scan_reg.mode == MODE_WORD && (letter || digit)) ||
                 (scan_reg.mode == MODE_NUMBER && (digit || c == "."));

        started       = SCAN_IDLE;
        started.mode  = letter ? MODE_WORD : MODE_NUMBER;
        started.kw    = letter ? 3'b111 : 3'b000;
        started.first = c;
        started       = append(started, c);

        // The pending token is closed out first unless this byte extends it.
        a_valid = !extend && (scan_reg.mode != MODE_IDLE);
        res_a   = flush_res(scan_reg);

        if (extend) begin
            mid = append(scan_reg, c);
        end else if (letter || digit) begin
            mid = started;
        end else begin
            mid = SCAN_IDLE;
        end

        // Second slot: the byte's own token, or the flush at end of text.
        res_b.kind  = op ? KIND_OPERATOR : KIND_UNRECOGNIZED;
        res_b.kwi   = 2'd0;
        res_b.len   = 7'd1;
        res_b.first = c;
        res_b.sat   = 1'b0;
        res_b.last  = 1'b0;
        b_valid     = 1'b0;
        if (!extend && !space && !letter && !digit) begin
            b_valid = 1'b1;
        end else if (s_tlast && mid.mode != MODE_IDLE) begin
            b_valid = 1'b1;
            res_b   = flush_res(mid);
        end

        r0      = a_valid ? res_a : res_b;
        r1      = res_b;
        r0.last = !(a_valid && b_valid);
        r1.last = 1'b1;
        n_res   = {1'b0, a_valid} + {1'b0, b_valid};

        scan_next = scan_reg;
        if (push) begin
            scan_next = s_tlast ? SCAN_IDLE : mid;
        end
    end

    // Result queue: entry 0 is the head; new tokens land behind what remains.
    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_sh[i] = (pop && i < QDEPTH - 1) ? q_reg[(i + 1) % QDEPTH] : q_reg[i];
        end
        base = count_reg - {1'b0, pop};
        for (int i = 0; i < QDEPTH; i++) begin
            q_next[i] = q_sh[i];
            if (push && n_res != 2'd0 && base == 2'(i)) begin
                q_next[i] = r0;
            end
            if (push && n_res == 2'd2 && base + 2'd1 == 2'(i)) begin
                q_next[i] = r1;
            end
        end
        count_next = base + (push ? n_res : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg  <= SCAN_IDLE;
            count_reg <= 2'd0;
        end else begin
            scan_reg  <= scan_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd3)
        else $error("result queue count out of range");

    a_end_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (scan_reg.mode == MODE_IDLE))
        else $error("scanner not idle after end of text");

    a_idle_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_reg.mode == MODE_IDLE) |-> (scan_reg.len == '0))
        else $error("idle scanner holds a length");

    a_pair_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (count_reg >= 2'd2))
        else $error("first token of a pair without its partner queued");

endmodule
